// ===== sv/hfd_pkg.sv =====
package hfd_pkg;

  localparam int PREFACE_BYTES = 24;
  localparam int HEADER_BYTES  = 9;

  localparam logic [1:0] ROLE_PREFACE = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  data_byte;
    logic        header_valid;
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] stream_ident;
    logic        frame_done;
    logic        preface_mismatch;
  } result_t;

  // client connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
  function automatic logic [7:0] preface_byte(input logic [4:0] pos);
    logic [7:0] val;
    unique case (pos)
      5'd0:    val = 8'h50;
      5'd1:    val = 8'h52;
      5'd2:    val = 8'h49;
      5'd3:    val = 8'h20;
      5'd4:    val = 8'h2A;
      5'd5:    val = 8'h20;
      5'd6:    val = 8'h48;
      5'd7:    val = 8'h54;
      5'd8:    val = 8'h54;
      5'd9:    val = 8'h50;
      5'd10:   val = 8'h2F;
      5'd11:   val = 8'h32;
      5'd12:   val = 8'h2E;
      5'd13:   val = 8'h30;
      5'd14:   val = 8'h0D;
      5'd15:   val = 8'h0A;
      5'd16:   val = 8'h0D;
      5'd17:   val = 8'h0A;
      5'd18:   val = 8'h53;
      5'd19:   val = 8'h4D;
      5'd20:   val = 8'h0D;
      5'd21:   val = 8'h0A;
      5'd22:   val = 8'h0D;
      5'd23:   val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/hfd_in_stage.sv =====
module hfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_byte
);
  import hfd_pkg::*;

  // register is free when empty or when its byte moves on this cycle
  assign in_stall = q_valid & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      q_byte <= rx_byte;
    end
  end

endmodule

// ===== sv/hfd_parser.sv =====
module hfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       q_byte,
  output hfd_pkg::result_t res
);
  import hfd_pkg::*;

  typedef enum logic [1:0] {
    PH_PREFACE = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [23:0] length_reg, length_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [31:0] stream_reg, stream_reg_next;
  logic [23:0] payload_remaining, payload_remaining_next;
  logic        mismatch_flag, mismatch_flag_next;

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    length_reg_next        = length_reg;
    type_reg_next          = type_reg;
    flags_reg_next         = flags_reg;
    stream_reg_next        = stream_reg;
    payload_remaining_next = payload_remaining;
    mismatch_flag_next     = mismatch_flag;
    res                    = '0;
    res.data_byte          = q_byte;

    unique case (phase)
      PH_PREFACE: begin
        res.byte_role = ROLE_PREFACE;
        if (byte_position >= 5'(PREFACE_BYTES) || preface_byte(byte_position) != q_byte) begin
          mismatch_flag_next = 1'b1;
        end
        if (byte_position >= 5'(PREFACE_BYTES - 1)) begin
          phase_next         = PH_HEADER;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        res.byte_role = ROLE_PAYLOAD;
        if (payload_remaining <= 24'd1) begin
          payload_remaining_next = '0;
          res.frame_done         = 1'b1;
          phase_next             = PH_HEADER;
          byte_position_next     = '0;
        end else begin
          payload_remaining_next = payload_remaining - 24'd1;
        end
      end
      default: begin
        // unused phase code behaves as the header phase
        res.byte_role = ROLE_HEADER;
        if (byte_position < 5'd3) begin
          length_reg_next = {length_reg[15:0], q_byte};
        end else if (byte_position == 5'd3) begin
          type_reg_next = q_byte;
        end else if (byte_position == 5'd4) begin
          flags_reg_next = q_byte;
        end else begin
          stream_reg_next = {stream_reg[23:0], q_byte};
        end

        if (byte_position >= 5'(HEADER_BYTES - 1)) begin
          res.header_valid   = 1'b1;
          res.frame_length   = length_reg;
          res.frame_type     = type_reg;
          res.frame_flags    = flags_reg;
          res.stream_ident   = stream_reg_next;
          byte_position_next = '0;
          if (length_reg == 24'd0) begin
            res.frame_done = 1'b1;
            phase_next     = PH_HEADER;
          end else begin
            payload_remaining_next = length_reg;
            phase_next             = PH_PAYLOAD;
          end
        end else begin
          byte_position_next = byte_position + 5'd1;
        end
      end
    endcase

    res.preface_mismatch = mismatch_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_PREFACE;
      byte_position     <= '0;
      length_reg        <= '0;
      type_reg          <= '0;
      flags_reg         <= '0;
      stream_reg        <= '0;
      payload_remaining <= '0;
      mismatch_flag     <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      length_reg        <= length_reg_next;
      type_reg          <= type_reg_next;
      flags_reg         <= flags_reg_next;
      stream_reg        <= stream_reg_next;
      payload_remaining <= payload_remaining_next;
      mismatch_flag     <= mismatch_flag_next;
    end
  end

endmodule

// ===== sv/hfd_out_stage.sv =====
module hfd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hfd_pkg::result_t res,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output hfd_pkg::result_t res_q
);
  import hfd_pkg::*;

  // result register loads whenever it is empty or being drained
  assign take = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= q_valid;
    end
    if (take && q_valid) begin
      res_q <= res;
    end
  end

endmodule

// ===== sv/http2_frame_deframer_core.sv =====
// HTTP/2 receive deframer: one connection byte in, one tagged byte out.
// Input channel in_valid/in_stall carries rx_byte; a byte transfers at a
// clock edge with in_valid high and in_stall low. The output channel
// out_valid/out_stall carries the role of each byte (preface, header,
// payload), the byte itself, the decoded header on the ninth header byte,
// the end-of-frame mark and the sticky preface mismatch flag.
// Throughput is one byte per cycle while out_stall is low. A byte is held
// in the input register, is parsed by a single pass of logic against the
// parse state, and lands in the result register, from which it may
// transfer out. When out_stall is high the result holds; the input
// register still takes one more byte, and in_stall rises only while both
// registers are full. Synchronous reset (rst high) empties both registers,
// returns the parser to the start of the 24-byte preface and clears the
// mismatch flag and the header fields.
module http2_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  byte_role,
  output logic [7:0]  data_byte,
  output logic        header_valid,
  output logic [23:0] frame_length,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [31:0] stream_ident,
  output logic        frame_done,
  output logic        preface_mismatch
);
  import hfd_pkg::*;

  logic       take;
  logic       q_valid;
  logic [7:0] q_byte;
  result_t    res;
  result_t    res_q;

  hfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (take),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  hfd_parser u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (q_valid & take),
    .q_byte (q_byte),
    .res    (res)
  );

  hfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign byte_role        = res_q.byte_role;
  assign data_byte        = res_q.data_byte;
  assign header_valid     = res_q.header_valid;
  assign frame_length     = res_q.frame_length;
  assign frame_type       = res_q.frame_type;
  assign frame_flags      = res_q.frame_flags;
  assign stream_ident     = res_q.stream_ident;
  assign frame_done       = res_q.frame_done;
  assign preface_mismatch = res_q.preface_mismatch;

`ifndef SYNTHESIS
  a_hdr_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid |-> byte_role == ROLE_HEADER)
    else $error("header_valid on a byte that is not a header byte");

  a_zero_len_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid && frame_length == 24'd0 |-> frame_done)
    else $error("zero-length frame not marked done");

  a_preface_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_PREFACE |-> !frame_done && !header_valid)
    else $error("frame marks on a preface byte");

  a_in_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register can drain");
`endif

endmodule

// ===== bench/http2_frame_deframer_core_tb.sv =====
`timescale 1ns / 100ps

module http2_frame_deframer_core_tb;
  import hfd_pkg::*;

  typedef enum logic [1:0] {
    PH_PREFACE = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } parse_phase_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    want;
  } stim_row_t;

  // "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n", first byte in the top bits
  localparam logic [191:0] CONN_PREFACE = {
    8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54,
    8'h54, 8'h50, 8'h2F, 8'h32, 8'h2E, 8'h30, 8'h0D, 8'h0A,
    8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A
  };
  localparam int RANDOM_BYTES = 1400;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  byte_role;
  logic [7:0]  data_byte;
  logic        header_valid;
  logic [23:0] frame_length;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [31:0] stream_ident;
  logic        frame_done;
  logic        preface_mismatch;

  // parser state mirrored by the predictor
  parse_phase_t parse_phase;
  logic [4:0]   parse_pos;
  logic [23:0]  length_acc;
  logic [7:0]   type_acc;
  logic [7:0]   flags_acc;
  logic [31:0]  stream_acc;
  logic [23:0]  payload_left;
  logic         preface_bad;

  result_t     pending_results[$];
  stim_row_t   stim_rows[$];
  result_t     seen;
  int          error_count = 0;
  int          bytes_sent = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          rx_left = 0;

  http2_frame_deframer_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_role        (byte_role),
    .data_byte        (data_byte),
    .header_valid     (header_valid),
    .frame_length     (frame_length),
    .frame_type       (frame_type),
    .frame_flags      (frame_flags),
    .stream_ident     (stream_ident),
    .frame_done       (frame_done),
    .preface_mismatch (preface_mismatch)
  );

  always #5 clk = ~clk;

  task automatic parse_byte(input logic [7:0] b, output result_t r);
    int idx;
    r = '0;
    r.data_byte = b;
    idx = int'(parse_pos);
    case (parse_phase)
      PH_PREFACE: begin
        r.byte_role = ROLE_PREFACE;
        if (idx >= PREFACE_BYTES || CONN_PREFACE[191 - 8*idx -: 8] != b)
          preface_bad = 1'b1;
        if (idx + 1 >= PREFACE_BYTES) begin
          parse_phase = PH_HEADER;
          parse_pos = '0;
        end else begin
          parse_pos = parse_pos + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        // an empty count also closes the frame
        if (payload_left <= 24'd1) begin
          payload_left = '0;
          r.frame_done = 1'b1;
          parse_phase = PH_HEADER;
          parse_pos = '0;
        end else begin
          payload_left = payload_left - 24'd1;
        end
      end
      default: begin
        r.byte_role = ROLE_HEADER;
        if (idx < 3)       length_acc = {length_acc[15:0], b};
        else if (idx == 3) type_acc = b;
        else if (idx == 4) flags_acc = b;
        else               stream_acc = {stream_acc[23:0], b};
        if (idx + 1 >= HEADER_BYTES) begin
          r.header_valid = 1'b1;
          r.frame_length = length_acc;
          r.frame_type   = type_acc;
          r.frame_flags  = flags_acc;
          r.stream_ident = stream_acc;
          parse_pos = '0;
          if (length_acc == 24'd0) begin
            r.frame_done = 1'b1;
            parse_phase = PH_HEADER;
          end else begin
            payload_left = length_acc;
            parse_phase = PH_PAYLOAD;
          end
        end else begin
          parse_pos = parse_pos + 5'd1;
        end
      end
    endcase
    r.preface_mismatch = preface_bad;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    int gap;
    result_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, predicted);
    pending_results.push_back(typed ? want : predicted);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [23:0] len, input int payload_count);
    logic [31:0] sid;
    sid = $urandom;
    tx_burst = ($urandom_range(0, 3) == 0);
    send_byte(len[23:16], 1'b0, '0);
    send_byte(len[15:8], 1'b0, '0);
    send_byte(len[7:0], 1'b0, '0);
    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    send_byte(sid[31:24], 1'b0, '0);
    send_byte(sid[23:16], 1'b0, '0);
    send_byte(sid[15:8], 1'b0, '0);
    send_byte(sid[7:0], 1'b0, '0);
    repeat (payload_count) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed, input result_t want);
    stim_row_t row;
    row.b = b;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // result side: one transfer per accepted output
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{byte_role, data_byte, header_valid, frame_length, frame_type,
               frame_flags, stream_ident, frame_done, preface_mismatch};
      if (pending_results.size() == 0) begin
        log_error($sformatf("unexpected result data %02h role %0d", data_byte, byte_role));
      end else if (seen !== pending_results[0]) begin
        log_error($sformatf(
          "exp role %0d byte %02h hv %0b len %06h type %02h flags %02h sid %08h done %0b pm %0b",
          pending_results[0].byte_role, pending_results[0].data_byte,
          pending_results[0].header_valid, pending_results[0].frame_length,
          pending_results[0].frame_type, pending_results[0].frame_flags,
          pending_results[0].stream_ident, pending_results[0].frame_done,
          pending_results[0].preface_mismatch));
        if (error_count <= MAX_REPORTS)
          $display(
            "got role %0d byte %02h hv %0b len %06h type %02h flags %02h sid %08h done %0b pm %0b",
            byte_role, data_byte, header_valid, frame_length, frame_type, frame_flags,
            stream_ident, frame_done, preface_mismatch);
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      int hold;
      if (rx_left == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
        rx_left = 32;
      end
      rx_left--;
      hold = rx_burst ? 0 : $urandom_range(0, 4);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [23:0] len;
    bit paused;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    parse_phase  = PH_PREFACE;
    parse_pos    = '0;
    length_acc   = '0;
    type_acc     = '0;
    flags_acc    = '0;
    stream_acc   = '0;
    payload_left = '0;
    preface_bad  = 1'b0;
    paused       = 1'b0;

    // preface with the last byte corrupted, so the sticky flag rises late
    add_row(8'h50, 1'b1, '{ROLE_PREFACE, 8'h50, 1'b0, 24'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0});
    for (int i = 1; i < PREFACE_BYTES - 1; i++)
      add_row(CONN_PREFACE[191 - 8*i -: 8], 1'b0, '0);
    add_row(8'hFF, 1'b1, '{ROLE_PREFACE, 8'hFF, 1'b0, 24'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b1});
    // zero-length frame, all other header fields at max
    for (int i = 0; i < 3; i++) add_row(8'h00, 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b1,
            '{ROLE_HEADER, 8'hFF, 1'b1, 24'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1});
    // one-byte frame, header fields at zero
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h01, 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b1,
            '{ROLE_HEADER, 8'h00, 1'b1, 24'd1, 8'd0, 8'd0, 32'd0, 1'b0, 1'b1});
    add_row(8'hA5, 1'b1,
            '{ROLE_PAYLOAD, 8'hA5, 1'b0, 24'd0, 8'd0, 8'd0, 32'd0, 1'b1, 1'b1});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) send_byte(stim_rows[i].b, stim_rows[i].typed, stim_rows[i].want);

    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) len = 24'($urandom_range(17, 300));
      else                           len = 24'($urandom_range(0, 16));
      send_frame(len, len);
      if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
        drain_results;
        paused = 1'b1;
      end
    end
    // longest length field; the frame stays open past the end of the run
    send_frame(24'hFF_FFFF, 6);

    drain_results;
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== http2_frame_deframer_core.f =====
sv/hfd_pkg.sv
sv/hfd_in_stage.sv
sv/hfd_parser.sv
sv/hfd_out_stage.sv
sv/http2_frame_deframer_core.sv
bench/http2_frame_deframer_core_tb.sv
